@@ hdl/rbn_pkg.sv @@
package rbn_pkg;

  localparam int WINDOW      = 32;
  localparam int NACK_COUNT  = 5;
  localparam int MAX_RESULTS = 32;

  localparam int SEQ_W  = 20;
  localparam int PAY_W  = 64;
  localparam int KIND_W = 2;

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
  localparam int NACK_W = $clog2(NACK_COUNT + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [KIND_W-1:0] KIND_DELIVER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MISSING  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;

  typedef struct packed {
    logic             command;
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [PAY_W-1:0]  out_payload;
    logic              last;
  } out_item_t;

endpackage

@@ hdl/rbn_queue.sv @@
module rbn_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rbn_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output rbn_pkg::in_item_t out_item
);

  rbn_pkg::in_item_t slots_r [rbn_pkg::QDEPTH];

  logic [rbn_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [rbn_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [rbn_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                       push, pop;

  assign in_ready  = (count_r != rbn_pkg::QCNT_W'(rbn_pkg::QDEPTH));
  assign out_valid = (count_r != '0);
  assign out_item  = slots_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == rbn_pkg::QPTR_W'(rbn_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == rbn_pkg::QPTR_W'(rbn_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

@@ hdl/rbn_back.sv @@
module rbn_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rbn_pkg::SEQ_W-1:0] cfg_total_packets,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  rbn_pkg::in_item_t         item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rbn_pkg::out_item_t        out_item
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_PREP    = 3'd1;
  localparam logic [2:0] ST_RELEASE = 3'd2;
  localparam logic [2:0] ST_SCAN    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic [rbn_pkg::SEQ_W-1:0] WIN_SEQ = rbn_pkg::SEQ_W'(rbn_pkg::WINDOW);

  logic [2:0]                        state_r, state_nxt;
  logic [rbn_pkg::SEQ_W-1:0]         total_r, total_nxt;
  logic [rbn_pkg::SEQ_W-1:0]         ne_r, ne_nxt;
  logic [rbn_pkg::IDX_W-1:0]         head_r, head_nxt;
  logic [rbn_pkg::WINDOW-1:0]        full_r, full_nxt;
  logic [rbn_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [rbn_pkg::SEQ_W-1:0]         scan_r, scan_nxt;
  logic [rbn_pkg::NACK_W-1:0]        nfound_r, nfound_nxt;
  logic                              pend_valid_r, pend_valid_nxt;
  logic [rbn_pkg::SEQ_W-1:0]         pend_seq_r, pend_seq_nxt;
  logic                              out_valid_r, out_valid_nxt;
  rbn_pkg::out_item_t                out_r, out_nxt;

  logic [rbn_pkg::PAY_W-1:0]         mem [rbn_pkg::WINDOW];
  logic [rbn_pkg::PAY_W-1:0]         rd_r;

  logic                              out_free, emit;
  rbn_pkg::out_item_t                emit_data;
  logic [rbn_pkg::IDX_W-1:0]         head_inc;
  logic [rbn_pkg::SEQ_W-1:0]         off_a, off_s;
  logic [rbn_pkg::IDX_W-1:0]         idx_a, idx_s;
  logic                              store;
  logic                              can_rel, rel_last;
  logic                              held, loop_ok;

  function automatic logic [rbn_pkg::IDX_W-1:0] slot_of(
    input logic [rbn_pkg::IDX_W-1:0] head,
    input logic [rbn_pkg::SEQ_W-1:0] off
  );
    logic [rbn_pkg::IDX_W:0] sum;
    sum = (rbn_pkg::IDX_W+1)'(head) + (rbn_pkg::IDX_W+1)'(off[rbn_pkg::IDX_W-1:0]);
    if (sum >= (rbn_pkg::IDX_W+1)'(rbn_pkg::WINDOW)) begin
      sum = sum - (rbn_pkg::IDX_W+1)'(rbn_pkg::WINDOW);
    end
    return sum[rbn_pkg::IDX_W-1:0];
  endfunction

  assign cfg_ready  = 1'b1;
  assign item_ready = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_item   = out_r;
  assign out_free   = !out_valid_r || out_ready;

  assign head_inc = (head_r == rbn_pkg::IDX_W'(rbn_pkg::WINDOW - 1)) ? '0 : head_r + 1'b1;

  assign off_a = item.seq - ne_r;
  assign idx_a = slot_of(head_r, off_a);
  assign store = item_valid && (state_r == ST_IDLE) && (item.command == rbn_pkg::CMD_ARRIVAL)
                 && (item.seq >= ne_r) && (off_a < WIN_SEQ) && (item.seq < total_r)
                 && !full_r[idx_a];

  assign can_rel  = (ne_r < total_r) && full_r[head_r];
  assign rel_last = (cnt_r == rbn_pkg::CNT_W'(rbn_pkg::MAX_RESULTS - 1))
                    || (({1'b0, ne_r} + 1'b1) >= {1'b0, total_r})
                    || !full_r[head_inc];

  assign off_s   = scan_r - ne_r;
  assign idx_s   = slot_of(head_r, off_s);
  assign held    = (off_s < WIN_SEQ) && full_r[idx_s];
  assign loop_ok = (nfound_r < rbn_pkg::NACK_W'(rbn_pkg::NACK_COUNT)) && (scan_r < total_r);

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    ne_nxt         = ne_r;
    head_nxt       = head_r;
    full_nxt       = full_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    nfound_nxt     = nfound_r;
    pend_valid_nxt = pend_valid_r;
    pend_seq_nxt   = pend_seq_r;
    emit           = 1'b0;
    emit_data      = '0;

    if (cfg_valid) begin
      total_nxt = cfg_total_packets;
    end

    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          if (item.command == rbn_pkg::CMD_TICK) begin
            scan_nxt       = ne_r;
            nfound_nxt     = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = (ne_r >= total_r) ? ST_DONE : ST_SCAN;
          end else begin
            if (store) begin
              full_nxt[idx_a] = 1'b1;
            end
            cnt_nxt   = '0;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        state_nxt = ST_RELEASE;
      end
      ST_RELEASE: begin
        if (!can_rel) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          emit                  = 1'b1;
          emit_data.kind        = rbn_pkg::KIND_DELIVER;
          emit_data.out_seq     = ne_r;
          emit_data.out_payload = rd_r;
          emit_data.last        = rel_last;
          full_nxt[head_r]      = 1'b0;
          ne_nxt                = ne_r + 1'b1;
          head_nxt              = head_inc;
          cnt_nxt               = cnt_r + 1'b1;
          if (rel_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (loop_ok) begin
          if (held) begin
            scan_nxt = scan_r + 1'b1;
          end else if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              emit              = 1'b1;
              emit_data.kind    = rbn_pkg::KIND_MISSING;
              emit_data.out_seq = pend_seq_r;
            end
            pend_valid_nxt = 1'b1;
            pend_seq_nxt   = scan_r;
            nfound_nxt     = nfound_r + 1'b1;
            scan_nxt       = scan_r + 1'b1;
          end
        end else if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          emit              = 1'b1;
          emit_data.kind    = rbn_pkg::KIND_MISSING;
          emit_data.out_seq = pend_seq_r;
          emit_data.last    = 1'b1;
          pend_valid_nxt    = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit              = 1'b1;
          emit_data.kind    = rbn_pkg::KIND_COMPLETE;
          emit_data.out_seq = ne_r;
          emit_data.last    = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = emit_data;
    end else begin
      out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
      out_nxt       = out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      ne_r         <= '0;
      head_r       <= '0;
      full_r       <= '0;
      cnt_r        <= '0;
      scan_r       <= '0;
      nfound_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      ne_r         <= ne_nxt;
      head_r       <= head_nxt;
      full_r       <= full_nxt;
      cnt_r        <= cnt_nxt;
      scan_r       <= scan_nxt;
      nfound_r     <= nfound_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_seq_r <= pend_seq_nxt;
    out_r      <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[idx_a] <= item.payload;
    end
    rd_r <= mem[head_nxt];
  end

endmodule

@@ hdl/reorder_buffer_with_nack_list.sv @@
// Channel   Ports                                    Direction
// in        in_valid, in_ready, in_item              packet or tick into the block
// out       out_valid, out_ready, out_item           deliveries, missing reports, completion
// cfg       cfg_valid, cfg_ready, cfg_total_packets  total packet count write
// A packet passes a two-entry queue and then the back end's IDLE, PREP and RELEASE states
// before its first result; releases free one window slot per cycle unless output stalls.
// A tick walks one number per cycle unless output stalls, up to window plus report count.
// Reset is synchronous and active low; it clears the slot flags and the expected number.
// A stalled output holds the back end in place while the queue keeps taking items until full.
module reorder_buffer_with_nack_list (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rbn_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rbn_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rbn_pkg::SEQ_W-1:0] cfg_total_packets
);

  logic              q_valid;
  logic              q_ready;
  rbn_pkg::in_item_t q_item;

  rbn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  rbn_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_total_packets (cfg_total_packets),
    .item_valid        (q_valid),
    .item_ready        (q_ready),
    .item              (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item          (out_item)
  );

endmodule

@@ test/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FROM_MODEL      = -1;
  localparam int          SETTLE_CYCLES   = 64;
  localparam int          STALL_LIMIT     = 5000;
  localparam int          ITEMS_PER_PHASE = 34;
  localparam int unsigned SEQ_MASK        = (1 << rbn_pkg::SEQ_W) - 1;

  typedef enum {ROW_ITEM, ROW_TOTAL} row_kind_t;

  typedef struct {
    row_kind_t                 what;
    rbn_pkg::in_item_t         item;
    logic [rbn_pkg::SEQ_W-1:0] total;
    int                        n_typed;
    rbn_pkg::out_item_t        typed;
  } script_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  rbn_pkg::in_item_t         in_item;
  logic                      out_valid;
  logic                      out_ready;
  rbn_pkg::out_item_t        out_item;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [rbn_pkg::SEQ_W-1:0] cfg_total_packets;

  reorder_buffer_with_nack_list u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_item           (in_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_item          (out_item),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_total_packets (cfg_total_packets)
  );

  bit                        slot_held [rbn_pkg::WINDOW];
  logic [rbn_pkg::PAY_W-1:0] slot_pay  [rbn_pkg::WINDOW];
  int unsigned               next_seq;
  int unsigned               total_pkts;
  bit                        item_stored;

  rbn_pkg::out_item_t step_results[$];
  rbn_pkg::out_item_t pending_results[$];
  rbn_pkg::in_item_t  packet_plan[$];
  script_row_t        script[$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int items_sent     = 0;
  int useful_items   = 0;
  int n_deliver      = 0;
  int n_missing      = 0;
  int n_complete     = 0;
  int stall_cycles   = 0;
  int in_idle_pct    = 0;
  int out_idle_pct   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rbn_pkg::out_item_t make_result(input logic [rbn_pkg::KIND_W-1:0] k,
                                                     input int unsigned sq,
                                                     input logic [rbn_pkg::PAY_W-1:0] pl);
    rbn_pkg::out_item_t r;
    r.kind        = k;
    r.out_seq     = sq[rbn_pkg::SEQ_W-1:0];
    r.out_payload = pl;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic rbn_pkg::in_item_t make_item(input logic cmd, input int unsigned sq);
    rbn_pkg::in_item_t it;
    it.command = cmd;
    it.seq     = sq[rbn_pkg::SEQ_W-1:0];
    it.payload = {$urandom, $urandom};
    return it;
  endfunction

  function automatic void predict_results(input rbn_pkg::in_item_t it);
    int unsigned        s;
    rbn_pkg::out_item_t r;
    step_results.delete();
    item_stored = 1'b0;
    if (it.command == rbn_pkg::CMD_TICK) begin
      if (next_seq >= total_pkts) begin
        step_results.push_back(make_result(rbn_pkg::KIND_COMPLETE, next_seq, '0));
      end else begin
        s = next_seq;
        while (step_results.size() < rbn_pkg::NACK_COUNT &&
               step_results.size() < rbn_pkg::MAX_RESULTS && s < total_pkts) begin
          if (s - next_seq >= rbn_pkg::WINDOW || !slot_held[s % rbn_pkg::WINDOW]) begin
            step_results.push_back(make_result(rbn_pkg::KIND_MISSING, s, '0));
          end
          s++;
        end
      end
    end else begin
      s = it.seq;
      if (s >= next_seq && s - next_seq < rbn_pkg::WINDOW && s < total_pkts &&
          !slot_held[s % rbn_pkg::WINDOW]) begin
        slot_held[s % rbn_pkg::WINDOW] = 1'b1;
        slot_pay[s % rbn_pkg::WINDOW]  = it.payload;
        item_stored                    = 1'b1;
      end
      while (step_results.size() < rbn_pkg::MAX_RESULTS && next_seq < total_pkts &&
             slot_held[next_seq % rbn_pkg::WINDOW]) begin
        step_results.push_back(make_result(rbn_pkg::KIND_DELIVER, next_seq,
                                           slot_pay[next_seq % rbn_pkg::WINDOW]));
        slot_held[next_seq % rbn_pkg::WINDOW] = 1'b0;
        next_seq = (next_seq + 1) & SEQ_MASK;
      end
    end
    if (step_results.size() > 0) begin
      r      = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
  endfunction

  function automatic void add_pkt(input logic cmd, input int unsigned sq,
                                  input logic [rbn_pkg::PAY_W-1:0] pl, input int n_typed,
                                  input rbn_pkg::out_item_t typed);
    script_row_t row;
    row.what          = ROW_ITEM;
    row.item.command  = cmd;
    row.item.seq      = sq[rbn_pkg::SEQ_W-1:0];
    row.item.payload  = pl;
    row.total         = '0;
    row.n_typed       = n_typed;
    row.typed         = typed;
    row.typed.last    = 1'b1;
    script.push_back(row);
  endfunction

  function automatic void add_total(input int unsigned v);
    script_row_t row;
    row.what    = ROW_TOTAL;
    row.item    = '0;
    row.total   = v[rbn_pkg::SEQ_W-1:0];
    row.n_typed = 0;
    row.typed   = '0;
    script.push_back(row);
  endfunction

  task automatic send_item(input rbn_pkg::in_item_t it, input int n_typed,
                           input rbn_pkg::out_item_t typed);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predict_results(it);
    items_sent++;
    if (it.command == rbn_pkg::CMD_TICK || item_stored) begin
      useful_items++;
    end
    if (n_typed == FROM_MODEL) begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end else if (n_typed == 1) begin
      pending_results.push_back(typed);
    end
  endtask

  task automatic drain(input bit settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_total(input int unsigned v);
    drain(1'b1);
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_total_packets <= v[rbn_pkg::SEQ_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    total_pkts = v & SEQ_MASK;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_burst();
    int unsigned base;
    int unsigned len;
    int unsigned pick;
    int unsigned tmp;
    int unsigned sq;
    bit          rev;
    int unsigned order[$];
    base = next_seq;
    if ($urandom_range(0, 9) < 7) begin
      len = ($urandom_range(0, 3) == 0) ? rbn_pkg::WINDOW : $urandom_range(1, 12);
      rev = (len == rbn_pkg::WINDOW) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) order.push_back(rev ? base + len - 1 - i : base + i);
      if (!rev) begin
        for (int i = len - 1; i > 0; i--) begin
          pick        = $urandom_range(0, i);
          tmp         = order[i];
          order[i]    = order[pick];
          order[pick] = tmp;
        end
        if (len > 1 && $urandom_range(0, 3) == 0) begin
          void'(order.pop_back());
        end
      end
      foreach (order[i]) begin
        if ((rev && i == order.size() - 1) || $urandom_range(0, 5) == 0) begin
          packet_plan.push_back(make_item(rbn_pkg::CMD_TICK, $urandom_range(0, SEQ_MASK)));
        end
        packet_plan.push_back(make_item(rbn_pkg::CMD_ARRIVAL, order[i]));
        if ($urandom_range(0, 9) == 0) begin
          packet_plan.push_back(make_item(rbn_pkg::CMD_ARRIVAL, order[i]));
        end
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0: begin
            sq = (base == 0) ? 0 : $urandom_range(0, base - 1);
            packet_plan.push_back(make_item(rbn_pkg::CMD_ARRIVAL, sq));
          end
          1: begin
            packet_plan.push_back(make_item(rbn_pkg::CMD_ARRIVAL,
                                            base + rbn_pkg::WINDOW + $urandom_range(0, 200)));
          end
          2: begin
            packet_plan.push_back(make_item(rbn_pkg::CMD_ARRIVAL, $urandom_range(0, SEQ_MASK)));
          end
          default: begin
            packet_plan.push_back(make_item(rbn_pkg::CMD_TICK, $urandom_range(0, SEQ_MASK)));
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input logic [rbn_pkg::PAY_W-1:0] want,
                             input logic [rbn_pkg::PAY_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    rbn_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result kind %0d seq %0d payload %h last %0d, none expected",
                 $time, out_item.kind, out_item.out_seq, out_item.out_payload, out_item.last);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, out_item.kind);
        check_field("out_seq", want.out_seq, out_item.out_seq);
        check_field("out_payload", want.out_payload, out_item.out_payload);
        check_field("last", want.last, out_item.last);
        case (want.kind)
          rbn_pkg::KIND_DELIVER: n_deliver++;
          rbn_pkg::KIND_MISSING: n_missing++;
          default:               n_complete++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rbn_pkg::in_item_t it;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_item           = '0;
    cfg_valid         = 1'b0;
    cfg_total_packets = '0;
    next_seq          = 0;
    total_pkts        = 0;
    for (int i = 0; i < rbn_pkg::WINDOW; i++) begin
      slot_held[i] = 1'b0;
      slot_pay[i]  = '0;
    end

    add_pkt(rbn_pkg::CMD_TICK, 'h5A5A5, '1, 1, make_result(rbn_pkg::KIND_COMPLETE, 0, '0));
    add_pkt(rbn_pkg::CMD_ARRIVAL, 0, '1, 0, '0);
    add_total(0);
    add_pkt(rbn_pkg::CMD_TICK, SEQ_MASK, '0, 1, make_result(rbn_pkg::KIND_COMPLETE, 0, '0));
    add_total(40);
    add_pkt(rbn_pkg::CMD_TICK, 0, '0, FROM_MODEL, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 0, '1, 1, make_result(rbn_pkg::KIND_DELIVER, 0, '1));
    add_pkt(rbn_pkg::CMD_ARRIVAL, 0, 64'h5, 0, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 2, 64'h2, 0, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 2, 64'h3, 0, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 33, '1, 0, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 32, 64'hA5A5_5A5A_A5A5_5A5A, 0, '0);
    add_pkt(rbn_pkg::CMD_TICK, 'hFFFFF, '1, FROM_MODEL, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 1, '0, FROM_MODEL, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 3, 64'h0123_4567_89AB_CDEF, 1,
            make_result(rbn_pkg::KIND_DELIVER, 3, 64'h0123_4567_89AB_CDEF));
    add_total(2);
    add_pkt(rbn_pkg::CMD_TICK, 0, '0, 1, make_result(rbn_pkg::KIND_COMPLETE, 4, '0));
    add_pkt(rbn_pkg::CMD_ARRIVAL, 5, '1, 0, '0);
    add_total(999999);
    add_pkt(rbn_pkg::CMD_TICK, 0, '0, FROM_MODEL, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 999999, '1, 0, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, SEQ_MASK, '1, 0, '0);
    add_pkt(rbn_pkg::CMD_ARRIVAL, 4, '0, 1, make_result(rbn_pkg::KIND_DELIVER, 4, '0));
    add_pkt(rbn_pkg::CMD_TICK, 0, '0, FROM_MODEL, '0);

    in_idle_pct  = 14;
    out_idle_pct = 66;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].what == ROW_TOTAL) begin
        write_total(script[i].total);
      end else begin
        send_item(script[i].item, script[i].n_typed, script[i].typed);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct  = 14;
          out_idle_pct = 66;
          write_total(next_seq + $urandom_range(60, 160));
        end
        1: begin
          in_idle_pct  = 66;
          out_idle_pct = 14;
          write_total(999999);
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
          write_total(next_seq + $urandom_range(30, 60));
        end
      endcase
      packet_plan.delete();
      for (int goal = items_sent + ITEMS_PER_PHASE; items_sent < goal; ) begin
        if (packet_plan.size() == 0) begin
          plan_burst();
        end
        it = packet_plan.pop_front();
        if ($urandom_range(0, 24) == 0) begin
          drain(1'b0);
        end
        send_item(it, FROM_MODEL, '0);
      end
    end

    drain(1'b1);
    $display("Sent %0d items (%0d stored packets or ticks) under several packet totals %s",
             items_sent, useful_items, "and three stall mixes.");
    $display("Checked %0d results: %0d deliveries, %0d missing reports, %0d completions.",
             results_seen, n_deliver, n_missing, n_complete);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
